FILE: design/inertial_state_predict_step_assert.svh
// assertion macros used by the predict step sequencer
// each expects clk and rst_n in the scope where it is used
`ifndef INERTIAL_STATE_PREDICT_STEP_ASSERT_SVH
`define INERTIAL_STATE_PREDICT_STEP_ASSERT_SVH

// same-cycle implication
`define ISPS_AST_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define ISPS_AST_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

FILE: design/isps_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// isps_pkg
// types, constants and the step program of the state predict block
// ----------------------------------------------------------------------------
package isps_pkg;

  localparam int EW      = 48;   // element width
  localparam int FB      = 24;   // fraction bits
  localparam int NREG    = 32;   // register file depth
  localparam int AW      = 5;
  localparam int PC_W    = 6;
  localparam int CNT_W   = 7;
  localparam int BND_W   = 27;

  localparam logic [PC_W-1:0]  PC_LAST  = 6'd62;
  localparam logic [CNT_W-1:0] MUL_END  = 7'd4;
  localparam logic [CNT_W-1:0] SQRT_END = 7'd36;
  localparam logic [CNT_W-1:0] DIV_END  = 7'd72;

  // dt = floor((ms * 2^21 + 62) / 125), by reciprocal multiply and shift
  localparam logic [EW-1:0] DT_RECIP = 48'h0041_8937_4BC7;
  localparam logic [EW-1:0] DT_BIAS  = 48'd62;
  localparam int            DT_SHIFT = 45;

  localparam logic [BND_W-1:0] NORM_LOW_RST  = 27'd16609444;
  localparam logic [BND_W-1:0] NORM_HIGH_RST = 27'd16944988;

  // input function codes
  localparam logic FUNC_WRITE = 1'b0;
  localparam logic FUNC_PRED  = 1'b1;

  // register indexes on the config port
  localparam logic REG_NORM_LOW  = 1'b0;
  localparam logic REG_NORM_HIGH = 1'b1;

  // step operation codes
  localparam logic [2:0] OP_DT   = 3'd0;
  localparam logic [2:0] OP_FACT = 3'd1;
  localparam logic [2:0] OP_MUL  = 3'd2;
  localparam logic [2:0] OP_ADD  = 3'd3;
  localparam logic [2:0] OP_SUB  = 3'd4;
  localparam logic [2:0] OP_SQRT = 3'd5;
  localparam logic [2:0] OP_NRM  = 3'd6;

  // state elements
  localparam logic [AW-1:0] E_WX = 5'd0;
  localparam logic [AW-1:0] E_WY = 5'd1;
  localparam logic [AW-1:0] E_WZ = 5'd2;
  localparam logic [AW-1:0] E_AX = 5'd3;
  localparam logic [AW-1:0] E_AY = 5'd4;
  localparam logic [AW-1:0] E_AZ = 5'd5;
  localparam logic [AW-1:0] E_VX = 5'd6;
  localparam logic [AW-1:0] E_VY = 5'd7;
  localparam logic [AW-1:0] E_VZ = 5'd8;
  localparam logic [AW-1:0] E_PX = 5'd9;
  localparam logic [AW-1:0] E_PY = 5'd10;
  localparam logic [AW-1:0] E_PZ = 5'd11;
  localparam logic [AW-1:0] E_Q1 = 5'd12;
  localparam logic [AW-1:0] E_Q2 = 5'd13;
  localparam logic [AW-1:0] E_Q3 = 5'd14;
  localparam logic [AW-1:0] E_Q4 = 5'd15;

  // scratch registers
  localparam logic [AW-1:0] R_DT   = 5'd16;
  localparam logic [AW-1:0] R_FACT = 5'd17;
  localparam logic [AW-1:0] R_T0   = 5'd18;
  localparam logic [AW-1:0] R_T1   = 5'd19;
  localparam logic [AW-1:0] R_T2   = 5'd20;
  localparam logic [AW-1:0] R_T3   = 5'd21;
  localparam logic [AW-1:0] R_N1   = 5'd22;
  localparam logic [AW-1:0] R_N2   = 5'd23;
  localparam logic [AW-1:0] R_N3   = 5'd24;
  localparam logic [AW-1:0] R_N4   = 5'd25;
  localparam logic [AW-1:0] R_E    = 5'd26;

  // flag targets beyond the element flags
  localparam logic [AW-1:0] FL_E    = 5'd16;
  localparam logic [AW-1:0] FL_NONE = 5'd17;

  localparam logic [72:0] MAG_NEG = 73'(1) << (EW - 1);
  localparam logic [72:0] MAG_POS = MAG_NEG - 73'(1);

  typedef struct packed {
    logic [2:0]    op;
    logic [AW-1:0] a;
    logic [AW-1:0] b;
    logic [AW-1:0] d;
    logic [AW-1:0] fl;
  } uop_t;

  typedef struct packed {
    logic          wr_item;
    logic          pred;
    logic          rd_en;
    logic [AW-1:0] rd_a;
    logic [AW-1:0] rd_b;
    logic          start;
    uop_t          uop;
    logic          out_load;
    logic [3:0]    oidx;
  } cmd_t;

  typedef struct packed {
    logic done;
    logic busy;
  } sts_t;

  typedef struct packed {
    logic [EW-1:0] val;
    logic          ovf;
  } sat_t;

  function automatic uop_t uop(logic [2:0] op, logic [AW-1:0] a, logic [AW-1:0] b,
                               logic [AW-1:0] d, logic [AW-1:0] fl);
    uop_t r;
    r.op = op; r.a = a; r.b = b; r.d = d; r.fl = fl;
    return r;
  endfunction

  // magnitude and sign to a clamped element
  function automatic sat_t sat_mag(logic [72:0] m, logic neg);
    sat_t r;
    r.ovf = 1'b0;
    if (neg) begin
      if (m > MAG_NEG) begin
        r.val = {1'b1, {(EW-1){1'b0}}};
        r.ovf = 1'b1;
      end else begin
        r.val = EW'(~m[EW-1:0] + EW'(1));
      end
    end else begin
      if (m > MAG_POS) begin
        r.val = {1'b0, {(EW-1){1'b1}}};
        r.ovf = 1'b1;
      end else begin
        r.val = m[EW-1:0];
      end
    end
    return r;
  endfunction

  // saturating add or subtract
  function automatic sat_t sat_add(logic [EW-1:0] a, logic [EW-1:0] b, logic sub);
    sat_t r;
    logic [EW:0] s;
    s = sub ? ({a[EW-1], a} - {b[EW-1], b}) : ({a[EW-1], a} + {b[EW-1], b});
    r.ovf = s[EW] ^ s[EW-1];
    if (r.ovf) r.val = s[EW] ? {1'b1, {(EW-1){1'b0}}} : {1'b0, {(EW-1){1'b1}}};
    else r.val = s[EW-1:0];
    return r;
  endfunction

  function automatic logic [EW-1:0] mag(logic [EW-1:0] a);
    return a[EW-1] ? EW'(~a + EW'(1)) : a;
  endfunction

  // step program
  function automatic uop_t prog_rom(logic [PC_W-1:0] pc);
    uop_t r;
    case (pc)
      6'd0:  r = uop(OP_DT,   R_DT,   R_DT,  R_DT,   FL_NONE);
      6'd1:  r = uop(OP_FACT, R_DT,   R_DT,  R_FACT, FL_NONE);
      // x axis
      6'd2:  r = uop(OP_MUL,  R_DT,   E_AX,  R_T0,   E_VX);
      6'd3:  r = uop(OP_MUL,  R_DT,   E_AX,  R_T1,   E_PX);
      6'd4:  r = uop(OP_MUL,  R_FACT, R_T1,  R_T2,   E_PX);
      6'd5:  r = uop(OP_MUL,  R_DT,   E_VX,  R_T3,   E_PX);
      6'd6:  r = uop(OP_ADD,  R_T2,   R_T3,  R_T2,   E_PX);
      6'd7:  r = uop(OP_ADD,  R_T2,   E_PX,  E_PX,   E_PX);
      6'd8:  r = uop(OP_ADD,  E_VX,   R_T0,  E_VX,   E_VX);
      // y axis
      6'd9:  r = uop(OP_MUL,  R_DT,   E_AY,  R_T0,   E_VY);
      6'd10: r = uop(OP_MUL,  R_DT,   E_AY,  R_T1,   E_PY);
      6'd11: r = uop(OP_MUL,  R_FACT, R_T1,  R_T2,   E_PY);
      6'd12: r = uop(OP_MUL,  R_DT,   E_VY,  R_T3,   E_PY);
      6'd13: r = uop(OP_ADD,  R_T2,   R_T3,  R_T2,   E_PY);
      6'd14: r = uop(OP_ADD,  R_T2,   E_PY,  E_PY,   E_PY);
      6'd15: r = uop(OP_ADD,  E_VY,   R_T0,  E_VY,   E_VY);
      // z axis
      6'd16: r = uop(OP_MUL,  R_DT,   E_AZ,  R_T0,   E_VZ);
      6'd17: r = uop(OP_MUL,  R_DT,   E_AZ,  R_T1,   E_PZ);
      6'd18: r = uop(OP_MUL,  R_FACT, R_T1,  R_T2,   E_PZ);
      6'd19: r = uop(OP_MUL,  R_DT,   E_VZ,  R_T3,   E_PZ);
      6'd20: r = uop(OP_ADD,  R_T2,   R_T3,  R_T2,   E_PZ);
      6'd21: r = uop(OP_ADD,  R_T2,   E_PZ,  E_PZ,   E_PZ);
      6'd22: r = uop(OP_ADD,  E_VZ,   R_T0,  E_VZ,   E_VZ);
      // scalar part
      6'd23: r = uop(OP_MUL,  E_WX,   E_Q2,  R_T0,   E_Q1);
      6'd24: r = uop(OP_MUL,  E_WY,   E_Q3,  R_T1,   E_Q1);
      6'd25: r = uop(OP_ADD,  R_T0,   R_T1,  R_T0,   E_Q1);
      6'd26: r = uop(OP_MUL,  E_WZ,   E_Q4,  R_T1,   E_Q1);
      6'd27: r = uop(OP_ADD,  R_T0,   R_T1,  R_T0,   E_Q1);
      6'd28: r = uop(OP_MUL,  R_FACT, R_T0,  R_T0,   E_Q1);
      6'd29: r = uop(OP_SUB,  E_Q1,   R_T0,  R_N1,   E_Q1);
      // first vector part
      6'd30: r = uop(OP_MUL,  E_WX,   E_Q1,  R_T0,   E_Q2);
      6'd31: r = uop(OP_MUL,  E_WZ,   E_Q3,  R_T1,   E_Q2);
      6'd32: r = uop(OP_ADD,  R_T0,   R_T1,  R_T0,   E_Q2);
      6'd33: r = uop(OP_MUL,  E_WY,   E_Q4,  R_T1,   E_Q2);
      6'd34: r = uop(OP_SUB,  R_T0,   R_T1,  R_T0,   E_Q2);
      6'd35: r = uop(OP_MUL,  R_FACT, R_T0,  R_T0,   E_Q2);
      6'd36: r = uop(OP_ADD,  E_Q2,   R_T0,  R_N2,   E_Q2);
      // second vector part
      6'd37: r = uop(OP_MUL,  E_WY,   E_Q1,  R_T0,   E_Q3);
      6'd38: r = uop(OP_MUL,  E_WZ,   E_Q2,  R_T1,   E_Q3);
      6'd39: r = uop(OP_SUB,  R_T0,   R_T1,  R_T0,   E_Q3);
      6'd40: r = uop(OP_MUL,  E_WX,   E_Q4,  R_T1,   E_Q3);
      6'd41: r = uop(OP_ADD,  R_T0,   R_T1,  R_T0,   E_Q3);
      6'd42: r = uop(OP_MUL,  R_FACT, R_T0,  R_T0,   E_Q3);
      6'd43: r = uop(OP_ADD,  E_Q3,   R_T0,  R_N3,   E_Q3);
      // third vector part
      6'd44: r = uop(OP_MUL,  E_WZ,   E_Q1,  R_T0,   E_Q4);
      6'd45: r = uop(OP_MUL,  E_WY,   E_Q2,  R_T1,   E_Q4);
      6'd46: r = uop(OP_ADD,  R_T0,   R_T1,  R_T0,   E_Q4);
      6'd47: r = uop(OP_MUL,  E_WX,   E_Q3,  R_T1,   E_Q4);
      6'd48: r = uop(OP_SUB,  R_T0,   R_T1,  R_T0,   E_Q4);
      6'd49: r = uop(OP_MUL,  R_FACT, R_T0,  R_T0,   E_Q4);
      6'd50: r = uop(OP_ADD,  E_Q4,   R_T0,  R_N4,   E_Q4);
      // squared norm
      6'd51: r = uop(OP_MUL,  R_N1,   R_N1,  R_E,    FL_E);
      6'd52: r = uop(OP_MUL,  R_N2,   R_N2,  R_T0,   FL_E);
      6'd53: r = uop(OP_ADD,  R_E,    R_T0,  R_E,    FL_E);
      6'd54: r = uop(OP_MUL,  R_N3,   R_N3,  R_T0,   FL_E);
      6'd55: r = uop(OP_ADD,  R_E,    R_T0,  R_E,    FL_E);
      6'd56: r = uop(OP_MUL,  R_N4,   R_N4,  R_T0,   FL_E);
      6'd57: r = uop(OP_ADD,  R_E,    R_T0,  R_E,    FL_E);
      // band check, root and normalize
      6'd58: r = uop(OP_SQRT, R_E,    R_E,   R_E,    FL_NONE);
      6'd59: r = uop(OP_NRM,  R_N1,   R_N1,  E_Q1,   E_Q1);
      6'd60: r = uop(OP_NRM,  R_N2,   R_N2,  E_Q2,   E_Q2);
      6'd61: r = uop(OP_NRM,  R_N3,   R_N3,  E_Q3,   E_Q3);
      6'd62: r = uop(OP_NRM,  R_N4,   R_N4,  E_Q4,   E_Q4);
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

FILE: design/inertial_state_predict_step.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// inertial_state_predict_step
// navigation state propagation step with quaternion renormalization
// ----------------------------------------------------------------------------
//  port group | dir | contents
//  in_*       | in  | request: write one element or run one prediction
//  out_*      | out | 16 new state elements per prediction, tlast on the last
//  cfg_*      | in  | norm band registers, byte address 4*index
//
//  a write request gives no result
//  63 program steps through one shared unit, one at a time; the root and
//  normalize divide steps iterate only when the squared norm is outside the band
//  and not zero; a prediction ends with the result run: each result is read,
//  loaded and then held until out_tready, so an output stall holds the run
//  one request at a time; in_tready is high only while idle
//  reset is synchronous, clears control state and all elements read as zero
module inertial_state_predict_step (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [71:0] in_tdata,   // element_index[3:0], element_value[51:4], elapsed_ms[67:52]
  input  logic [0:0]  in_tuser,   // func
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [55:0] out_tdata,  // out_index[3:0], out_value[51:4]
  output logic        out_tlast,
  output logic [1:0]  out_tuser,  // saturated, norm_fault
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  isps_pkg::cmd_t              cmd;
  isps_pkg::sts_t              sts;
  logic [3:0]                  o_idx;
  logic [isps_pkg::EW-1:0]     o_val;
  logic                        o_sat, o_fault;
  logic                        cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;

  // sequencer
  isps_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_func    (in_tuser[0]),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd_o      (cmd),
    .sts_i      (sts)
  );

  // arithmetic and state
  isps_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_i     (cmd),
    .sts_o     (sts),
    .in_index  (in_tdata[3:0]),
    .in_value  (in_tdata[51:4]),
    .in_ms     (in_tdata[67:52]),
    .cfg_wr    (cfg_wr),
    .cfg_sel   (cfg_paddr[2]),
    .cfg_wdata (cfg_pwdata[isps_pkg::BND_W-1:0]),
    .cfg_rdata (cfg_prdata),
    .out_index (o_idx),
    .out_value (o_val),
    .out_sat   (o_sat),
    .out_fault (o_fault)
  );

  // result packing
  assign out_tdata = {4'd0, o_val, o_idx};
  assign out_tlast = o_idx == 4'd15;
  assign out_tuser = {o_fault, o_sat};

endmodule

FILE: design/isps_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// isps_ctrl
// sequencer: accepts requests, steps the program, sends the result run
// ----------------------------------------------------------------------------
`include "inertial_state_predict_step_assert.svh"

module isps_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  input  logic                in_func,
  output logic                out_tvalid,
  input  logic                out_tready,
  output isps_pkg::cmd_t      cmd_o,
  input  isps_pkg::sts_t      sts_i
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_RD   = 3'd1;
  localparam logic [2:0] S_GO   = 3'd2;
  localparam logic [2:0] S_WT   = 3'd3;
  localparam logic [2:0] S_ORD  = 3'd4;
  localparam logic [2:0] S_OLD  = 3'd5;
  localparam logic [2:0] S_OWT  = 3'd6;

  logic [2:0]                    state_r, state_nxt;
  logic [isps_pkg::PC_W-1:0]     pc_r, pc_nxt;
  logic [3:0]                    oidx_r, oidx_nxt;
  isps_pkg::uop_t                uop_cur;

  assign uop_cur = isps_pkg::prog_rom(pc_r);

  // next state and commands
  always_comb begin
    state_nxt      = state_r;
    pc_nxt         = pc_r;
    oidx_nxt       = oidx_r;
    in_tready      = 1'b0;
    out_tvalid     = 1'b0;
    cmd_o          = '0;
    cmd_o.uop      = uop_cur;
    cmd_o.rd_a     = uop_cur.a;
    cmd_o.rd_b     = uop_cur.b;
    cmd_o.oidx     = oidx_r;
    unique case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          if (in_func == isps_pkg::FUNC_PRED) begin
            cmd_o.pred = 1'b1;
            pc_nxt     = '0;
            state_nxt  = S_RD;
          end else begin
            cmd_o.wr_item = 1'b1;
          end
        end
      end
      S_RD: begin
        cmd_o.rd_en = 1'b1;
        state_nxt   = S_GO;
      end
      S_GO: begin
        cmd_o.start = 1'b1;
        state_nxt   = S_WT;
      end
      S_WT: begin
        if (sts_i.done) begin
          if (pc_r == isps_pkg::PC_LAST) begin
            oidx_nxt  = '0;
            state_nxt = S_ORD;
          end else begin
            pc_nxt    = pc_r + 1'b1;
            state_nxt = S_RD;
          end
        end
      end
      S_ORD: begin
        cmd_o.rd_en = 1'b1;
        cmd_o.rd_a  = {1'b0, oidx_r};
        state_nxt   = S_OLD;
      end
      S_OLD: begin
        cmd_o.out_load = 1'b1;
        state_nxt      = S_OWT;
      end
      S_OWT: begin
        out_tvalid = 1'b1;
        if (out_tready) begin
          if (oidx_r == 4'd15) begin
            state_nxt = S_IDLE;
          end else begin
            oidx_nxt  = oidx_r + 1'b1;
            state_nxt = S_ORD;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      pc_r    <= '0;
      oidx_r  <= '0;
    end else begin
      state_r <= state_nxt;
      pc_r    <= pc_nxt;
      oidx_r  <= oidx_nxt;
    end
  end

  // checks
  `ISPS_AST_IMP(a_done_in_wait, sts_i.done, state_r == S_WT, "unit done outside wait state")
  `ISPS_AST_NXT(a_pred_starts, state_r == S_IDLE && in_tvalid && in_func == isps_pkg::FUNC_PRED, state_r == S_RD && pc_r == '0, "predict request did not start program")
  `ISPS_AST_NXT(a_out_hold, state_r == S_OWT && !out_tready, state_r == S_OWT && $stable(oidx_r), "result index moved while stalled")
  `ISPS_AST_IMP(a_busy_wait, sts_i.busy, state_r == S_WT, "unit busy outside wait state")

endmodule

FILE: design/isps_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// isps_dp
// datapath: register file, chunked multiplier, root and divide units
// ----------------------------------------------------------------------------
module isps_dp (
  input  logic                       clk,
  input  logic                       rst_n,
  input  isps_pkg::cmd_t             cmd_i,
  output isps_pkg::sts_t             sts_o,
  input  logic [3:0]                 in_index,
  input  logic [isps_pkg::EW-1:0]    in_value,
  input  logic [15:0]                in_ms,
  input  logic                       cfg_wr,
  input  logic                       cfg_sel,
  input  logic [isps_pkg::BND_W-1:0] cfg_wdata,
  output logic [31:0]                cfg_rdata,
  output logic [3:0]                 out_index,
  output logic [isps_pkg::EW-1:0]    out_value,
  output logic                       out_sat,
  output logic                       out_fault
);

  localparam int EW = isps_pkg::EW;

  logic [EW-1:0]  rf_mem [isps_pkg::NREG];
  logic [15:0]    vld_r;
  logic [EW-1:0]  rda_r, rdb_r;
  logic           za_r, zb_r;
  logic [EW-1:0]  opa, opb;

  logic [isps_pkg::BND_W-1:0] low_r, high_r;

  logic                       busy_r, done;
  logic [2:0]                 op_r;
  logic [4:0]                 dst_r, fl_r;
  logic [isps_pkg::CNT_W-1:0] cnt_r;

  logic [EW-1:0]  ma_r, mb_r;
  logic           neg_r;
  logic [63:0]    pp_r;
  logic [95:0]    acc_r;
  logic [15:0]    chunk;
  logic [95:0]    pp_sh;
  logic [95:0]    rnd;

  logic [71:0]    num_r, quo_r;
  logic [36:0]    rem_r;
  logic [35:0]    dvs_r;
  logic [37:0]    rem_sh;
  logic           dge;

  logic [71:0]    rad_r;
  logic [37:0]    srem_r, srem_sh, trial;
  logic [35:0]    root_r;
  logic           sge;

  logic           norm_r, fault_r, ef_r;
  logic [15:0]    sf_r;
  logic [15:0]    ms_r;
  logic           outside;

  isps_pkg::sat_t res;
  logic           wb, wr_en;
  logic [4:0]     wr_addr;
  logic [EW-1:0]  wr_data;

  // operands, unwritten state elements read as zero
  assign opa = za_r ? '0 : rda_r;
  assign opb = zb_r ? '0 : rdb_r;

  // completion
  always_comb begin
    case (op_r)
      isps_pkg::OP_MUL,
      isps_pkg::OP_DT:   done = busy_r && cnt_r == isps_pkg::MUL_END;
      isps_pkg::OP_SQRT: done = busy_r && cnt_r == isps_pkg::SQRT_END;
      isps_pkg::OP_NRM:  done = busy_r && cnt_r == isps_pkg::DIV_END;
      default:           done = busy_r && cnt_r == '0;
    endcase
  end

  assign sts_o.done = done;
  assign sts_o.busy = busy_r;

  // multiplier chunk select and alignment
  always_comb begin
    case (cnt_r[1:0])
      2'd0:    chunk = mb_r[15:0];
      2'd1:    chunk = mb_r[31:16];
      default: chunk = mb_r[47:32];
    endcase
    case (cnt_r[1:0])
      2'd1:    pp_sh = {32'd0, pp_r};
      2'd2:    pp_sh = {16'd0, pp_r, 16'd0};
      default: pp_sh = {pp_r, 32'd0};
    endcase
  end

  // divide and root steps
  assign rem_sh  = {rem_r, num_r[71]};
  assign dge     = rem_sh >= {2'b00, dvs_r};
  assign srem_sh = {srem_r[35:0], rad_r[71:70]};
  assign trial   = {root_r, 2'b01};
  assign sge     = srem_sh >= trial;

  // norm band check
  assign outside = (opa < EW'(low_r)) || (opa > EW'(high_r));

  // result of the finished operation
  always_comb begin
    res = '0;
    rnd = acc_r + (96'(1) << (isps_pkg::FB - 1));
    case (op_r)
      isps_pkg::OP_MUL:  res = isps_pkg::sat_mag(73'(rnd[95:isps_pkg::FB]), neg_r);
      isps_pkg::OP_ADD:  res = isps_pkg::sat_add(opa, opb, 1'b0);
      isps_pkg::OP_SUB:  res = isps_pkg::sat_add(opa, opb, 1'b1);
      isps_pkg::OP_FACT: res.val = EW'(({opa[EW-1], opa} + (EW+1)'(1)) >> 1);
      isps_pkg::OP_DT:   res.val = acc_r[isps_pkg::DT_SHIFT +: EW];
      isps_pkg::OP_NRM: begin
        if (norm_r) begin
          res = isps_pkg::sat_mag({1'b0, quo_r} +
                                  73'({rem_r, 1'b0} >= {2'b00, dvs_r}), neg_r);
        end else begin
          res.val = opa;
        end
      end
      default: res = '0;
    endcase
  end

  // single write port
  assign wb      = done && op_r != isps_pkg::OP_SQRT;
  assign wr_en   = cmd_i.wr_item || wb;
  assign wr_addr = cmd_i.wr_item ? {1'b0, in_index} : dst_r;
  assign wr_data = cmd_i.wr_item ? in_value : res.val;

  // register file
  always_ff @(posedge clk) begin
    if (wr_en) rf_mem[wr_addr] <= wr_data;
    if (cmd_i.rd_en) begin
      rda_r <= rf_mem[cmd_i.rd_a];
      rdb_r <= rf_mem[cmd_i.rd_b];
      za_r  <= !cmd_i.rd_a[4] && !vld_r[cmd_i.rd_a[3:0]];
      zb_r  <= !cmd_i.rd_b[4] && !vld_r[cmd_i.rd_b[3:0]];
    end
  end

  // control state: valid bits, config, unit sequencing, flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r   <= '0;
      low_r   <= isps_pkg::NORM_LOW_RST;
      high_r  <= isps_pkg::NORM_HIGH_RST;
      busy_r  <= 1'b0;
      op_r    <= isps_pkg::OP_ADD;
      cnt_r   <= '0;
      norm_r  <= 1'b0;
      fault_r <= 1'b0;
      ef_r    <= 1'b0;
      sf_r    <= '0;
    end else begin
      if (wr_en && !wr_addr[4]) vld_r[wr_addr[3:0]] <= 1'b1;
      if (cfg_wr) begin
        if (cfg_sel == isps_pkg::REG_NORM_HIGH) high_r <= cfg_wdata;
        else low_r <= cfg_wdata;
      end
      if (cmd_i.pred) begin
        norm_r  <= 1'b0;
        fault_r <= 1'b0;
        ef_r    <= 1'b0;
        sf_r    <= '0;
      end
      if (cmd_i.start) begin
        busy_r <= 1'b1;
        op_r   <= cmd_i.uop.op;
        if (cmd_i.uop.op == isps_pkg::OP_SQRT) begin
          norm_r <= outside && opa != '0;
          if (outside && opa == '0) fault_r <= 1'b1;
        end
        if (cmd_i.uop.op == isps_pkg::OP_SQRT && (!outside || opa == '0))
          cnt_r <= isps_pkg::SQRT_END;
        else if (cmd_i.uop.op == isps_pkg::OP_NRM && !norm_r)
          cnt_r <= isps_pkg::DIV_END;
        else
          cnt_r <= '0;
      end else if (done) begin
        busy_r <= 1'b0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
      end
      if (done && res.ovf) begin
        if (!fl_r[4]) sf_r[fl_r[3:0]] <= 1'b1;
        else if (fl_r == isps_pkg::FL_E) ef_r <= 1'b1;
      end
    end
  end

  // unit payload
  always_ff @(posedge clk) begin
    if (cmd_i.pred) ms_r <= in_ms;
    if (cmd_i.start) begin
      dst_r  <= cmd_i.uop.d;
      fl_r   <= cmd_i.uop.fl;
      // dt runs on the multiplier: scaled ms times the reciprocal of 125
      ma_r   <= (cmd_i.uop.op == isps_pkg::OP_DT) ?
                EW'({ms_r, {(isps_pkg::FB-3){1'b0}}}) + isps_pkg::DT_BIAS :
                isps_pkg::mag(opa);
      mb_r   <= (cmd_i.uop.op == isps_pkg::OP_DT) ? isps_pkg::DT_RECIP : isps_pkg::mag(opb);
      neg_r  <= (cmd_i.uop.op == isps_pkg::OP_MUL) ? (opa[EW-1] ^ opb[EW-1]) : opa[EW-1];
      acc_r  <= '0;
      rem_r  <= '0;
      quo_r  <= '0;
      srem_r <= '0;
      rad_r  <= {opa, {isps_pkg::FB{1'b0}}};
      num_r  <= {isps_pkg::mag(opa), {isps_pkg::FB{1'b0}}};
      dvs_r  <= root_r;
      if (cmd_i.uop.op == isps_pkg::OP_SQRT) root_r <= '0;
    end else if (busy_r && !done) begin
      case (op_r)
        isps_pkg::OP_MUL,
        isps_pkg::OP_DT: begin
          if (cnt_r < 7'd3) pp_r <= ma_r * chunk;
          if (cnt_r != '0) acc_r <= acc_r + pp_sh;
        end
        isps_pkg::OP_NRM: begin
          rem_r <= dge ? 37'(rem_sh - {2'b00, dvs_r}) : rem_sh[36:0];
          quo_r <= {quo_r[70:0], dge};
          num_r <= {num_r[70:0], 1'b0};
        end
        isps_pkg::OP_SQRT: begin
          srem_r <= sge ? srem_sh - trial : srem_sh;
          root_r <= {root_r[34:0], sge};
          rad_r  <= {rad_r[69:0], 2'b00};
        end
        default: ;
      endcase
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd_i.out_load) begin
      out_index <= cmd_i.oidx;
      out_value <= opa;
      out_sat   <= sf_r[cmd_i.oidx] || (ef_r && cmd_i.oidx[3:2] == 2'b11);
      out_fault <= fault_r;
    end
  end

  // config read back
  assign cfg_rdata = (cfg_sel == isps_pkg::REG_NORM_HIGH) ? 32'(high_r) : 32'(low_r);

endmodule

FILE: sim/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// checks the navigation state predict step against a cycle-free predictor:
// element writes, prediction runs, norm band registers, saturation and the
// zero-norm fault, with random gaps on both stream sides
// ----------------------------------------------------------------------------
module tb_top;

  typedef logic signed [47:0] elem_t;
  typedef struct {
    logic [3:0] idx;
    elem_t      val;
    bit         last;
    bit         sat;
    bit         fault;
  } nav_result_t;

  localparam elem_t ELEM_HI = {1'b0, {47{1'b1}}};
  localparam elem_t ELEM_LO = {1'b1, {47{1'b0}}};
  localparam elem_t ONE     = 48'sd16777216;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [71:0] in_tdata = '0;   // element_index[3:0], element_value[51:4], elapsed_ms[67:52]
  logic [0:0]  in_tuser = '0;   // func
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [55:0] out_tdata;       // out_index[3:0], out_value[51:4]
  logic        out_tlast;
  logic [1:0]  out_tuser;       // saturated, norm_fault
  logic        cfg_psel = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite = 1'b0;
  logic [2:0]  cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  inertial_state_predict_step uut (.*);

  always #6 clk = ~clk;

  // predictor state
  elem_t       nav_model [16];
  logic [26:0] band_low = isps_pkg::NORM_LOW_RST;
  logic [26:0] band_high = isps_pkg::NORM_HIGH_RST;
  nav_result_t pending_results [$];
  int          errors = 0;
  bit          gaps_on = 1'b1;
  int          out_hold = 0;
  int          out_gap;

  initial for (int i = 0; i < 16; i++) nav_model[i] = '0;

  task automatic report(input string what, input logic [63:0] exp_v, input logic [63:0] got_v);
    $display("mismatch %s: expected %0h got %0h at %0t", what, exp_v, got_v, $realtime);
    errors++;
  endtask

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (!gaps_on || r < 60) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // fixed point helpers, saturating to the element range
  function automatic elem_t clamp_mag(logic [127:0] m, bit neg, inout bit f);
    if (neg) begin
      if (m > 128'h8000_0000_0000) begin f = 1'b1; return ELEM_LO; end
      return elem_t'(-m);
    end
    if (m > 128'h7fff_ffff_ffff) begin f = 1'b1; return ELEM_HI; end
    return elem_t'(m);
  endfunction

  function automatic logic [127:0] abs_of(elem_t a);
    logic signed [127:0] w;
    w = a;
    return w < 0 ? -w : w;
  endfunction

  function automatic elem_t sat_sum(elem_t a, elem_t b, bit sub, inout bit f);
    logic signed [49:0] s;
    s = sub ? (50'(a) - 50'(b)) : (50'(a) + 50'(b));
    if (s > 50'(ELEM_HI)) begin f = 1'b1; return ELEM_HI; end
    if (s < 50'(ELEM_LO)) begin f = 1'b1; return ELEM_LO; end
    return elem_t'(s);
  endfunction

  function automatic elem_t fx_mul(elem_t a, elem_t b, inout bit f);
    logic [127:0] m;
    m = (abs_of(a) * abs_of(b) + (128'd1 << 23)) >> 24;
    return clamp_mag(m, (a < 0) != (b < 0), f);
  endfunction

  function automatic logic [127:0] norm_root(logic [127:0] e);
    logic [127:0] x, r, c;
    x = e << 24;
    r = '0;
    for (int b = 46; b >= 0; b--) begin
      c = r | (128'd1 << b);
      if (c * c <= x) r = c;
    end
    return r;
  endfunction

  function automatic elem_t fx_div(elem_t q, logic [127:0] d, inout bit f);
    logic [127:0] n, quo, rem;
    n = abs_of(q) << 24;
    quo = n / d;
    rem = n % d;
    if (2 * rem >= d) quo++;
    return clamp_mag(quo, q < 0, f);
  endfunction

  // one prediction step: advance the state and queue the 16 new elements
  task automatic predict_step(input logic [15:0] ms);
    elem_t nx [16];
    bit    sf [16];
    elem_t dt, fact, dv, t, e;
    elem_t s [16];
    bit    ef, g, fault;
    logic [127:0] r;
    nav_result_t res;
    s = nav_model;
    ef = 0;
    fault = 0;
    dt = elem_t'((({112'd0, ms} << 24) + 500) / 1000);
    fact = (dt + 1) >>> 1;
    for (int i = 0; i < 3; i++) begin
      g = 0;
      dv = fx_mul(dt, s[3+i], g);
      nx[i] = s[i];
      nx[3+i] = s[3+i];
      sf[6+i] = g;
      sf[9+i] = g;
      nx[6+i] = sat_sum(s[6+i], dv, 0, sf[6+i]);
      t = sat_sum(fx_mul(fact, dv, sf[9+i]), fx_mul(dt, s[6+i], sf[9+i]), 0, sf[9+i]);
      nx[9+i] = sat_sum(t, s[9+i], 0, sf[9+i]);
    end
    for (int i = 12; i < 16; i++) sf[i] = 0;
    // quaternion rate update, scalar first
    t = sat_sum(sat_sum(fx_mul(s[0], s[13], sf[12]), fx_mul(s[1], s[14], sf[12]), 0, sf[12]),
                fx_mul(s[2], s[15], sf[12]), 0, sf[12]);
    nx[12] = sat_sum(s[12], fx_mul(fact, t, sf[12]), 1, sf[12]);
    t = sat_sum(sat_sum(fx_mul(s[0], s[12], sf[13]), fx_mul(s[2], s[14], sf[13]), 0, sf[13]),
                fx_mul(s[1], s[15], sf[13]), 1, sf[13]);
    nx[13] = sat_sum(s[13], fx_mul(fact, t, sf[13]), 0, sf[13]);
    t = sat_sum(sat_sum(fx_mul(s[1], s[12], sf[14]), fx_mul(s[2], s[13], sf[14]), 1, sf[14]),
                fx_mul(s[0], s[15], sf[14]), 0, sf[14]);
    nx[14] = sat_sum(s[14], fx_mul(fact, t, sf[14]), 0, sf[14]);
    t = sat_sum(sat_sum(fx_mul(s[2], s[12], sf[15]), fx_mul(s[1], s[13], sf[15]), 0, sf[15]),
                fx_mul(s[0], s[14], sf[15]), 1, sf[15]);
    nx[15] = sat_sum(s[15], fx_mul(fact, t, sf[15]), 0, sf[15]);
    // squared norm and band check
    e = '0;
    for (int i = 12; i < 16; i++) e = sat_sum(e, fx_mul(nx[i], nx[i], ef), 0, ef);
    if (ef) for (int i = 12; i < 16; i++) sf[i] = 1;
    if (e < elem_t'(band_low) || e > elem_t'(band_high)) begin
      if (e == 0) fault = 1;
      else begin
        r = norm_root(128'(e));
        for (int i = 12; i < 16; i++) nx[i] = fx_div(nx[i], r, sf[i]);
      end
    end
    for (int i = 0; i < 16; i++) begin
      nav_model[i] = nx[i];
      res.idx = 4'(i);
      res.val = nx[i];
      res.last = (i == 15);
      res.sat = sf[i];
      res.fault = fault;
      pending_results.push_back(res);
    end
  endtask

  // send one request and apply it to the predictor once accepted
  task automatic send_request(input logic func, input logic [3:0] idx, input elem_t val,
                              input logic [15:0] ms);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= func;
    in_tdata <= {4'd0, ms, val, idx};
    do @(posedge clk); while (!in_tready);
    if (func == isps_pkg::FUNC_WRITE) nav_model[idx] = val;
    else predict_step(ms);
  endtask

  task automatic write_elem(input logic [3:0] idx, input elem_t val);
    send_request(isps_pkg::FUNC_WRITE, idx, val, 16'($urandom));
  endtask

  task automatic run_predict(input logic [15:0] ms);
    send_request(isps_pkg::FUNC_PRED, 4'($urandom), elem_t'({$urandom, $urandom}), ms);
  endtask

  // wait until every expected element came back and the block is quiet
  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
  endtask

  task automatic write_band(input logic reg_idx, input logic [31:0] value);
    drain();
    cfg_psel <= 1'b1;
    cfg_pwrite <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_paddr <= {reg_idx, 2'b00};
    cfg_pwdata <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    if (reg_idx == isps_pkg::REG_NORM_LOW) band_low = value[26:0];
    else band_high = value[26:0];
  endtask

  function automatic elem_t small_val(int bits);
    return elem_t'($signed({1'b0, 31'($urandom_range(0, (1 << bits) - 1))})) -
           elem_t'(1 << (bits - 1));
  endfunction

  task automatic load_unit_attitude();
    write_elem(4'(isps_pkg::E_Q1), ONE + small_val(18));
    for (int i = 13; i < 16; i++) write_elem(4'(i), small_val(20));
  endtask

  // result checker
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_results.size() == 0) begin
        report("unexpected result", 64'(out_tdata), 64'(0));
      end else begin
        nav_result_t x;
        x = pending_results.pop_front();
        if (out_tdata[3:0] !== x.idx) report("index", 64'(x.idx), 64'(out_tdata[3:0]));
        if (out_tdata[51:4] !== x.val) report("value", 64'(x.val), 64'(out_tdata[51:4]));
        if (out_tlast !== x.last) report("last", 64'(x.last), 64'(out_tlast));
        if (out_tuser[0] !== x.sat) report("saturated", 64'(x.sat), 64'(out_tuser[0]));
        if (out_tuser[1] !== x.fault) report("norm_fault", 64'(x.fault), 64'(out_tuser[1]));
      end
    end
  end

  // result side back-pressure
  always @(posedge clk) begin
    if (out_hold > 0) begin
      out_tready <= 1'b0;
      out_hold <= out_hold - 1;
    end else begin
      out_gap = pick_gap();
      out_tready <= (out_gap == 0);
      out_hold <= (out_gap > 0) ? out_gap - 1 : 0;
    end
  end

  // all-zero state after reset: zero norm fault
  task automatic test_reset_state();
    run_predict(16'd10);
    run_predict(16'd0);
  endtask

  // field extremes and saturation of every path
  task automatic test_extremes();
    for (int i = 0; i < 16; i++) write_elem(4'(i), (i % 2) ? ELEM_HI : ELEM_LO);
    run_predict(16'hffff);
    write_elem(4'd0, ELEM_HI);
    write_elem(4'd15, elem_t'(48'h5555_5555_5555));
    write_elem(4'd14, elem_t'(48'haaaa_aaaa_aaaa));
    run_predict(16'd1);
    load_unit_attitude();
    for (int i = 0; i < 12; i++) write_elem(4'(i), '0);
    run_predict(16'd20);
  endtask

  // norm band registers: extremes, crossed bounds, masked upper bits
  task automatic test_band_settings();
    write_band(isps_pkg::REG_NORM_LOW, 32'd0);
    write_band(isps_pkg::REG_NORM_HIGH, 32'd67108864);
    load_unit_attitude();
    run_predict(16'd5);
    write_band(isps_pkg::REG_NORM_LOW, 32'hffff_ffff);
    write_band(isps_pkg::REG_NORM_HIGH, 32'd0);
    run_predict(16'd5);
    for (int i = 12; i < 16; i++) write_elem(4'(i), '0);
    run_predict(16'd3);
    write_band(isps_pkg::REG_NORM_LOW, 32'(isps_pkg::NORM_LOW_RST));
    write_band(isps_pkg::REG_NORM_HIGH, 32'(isps_pkg::NORM_HIGH_RST));
  endtask

  // flight-like sequences with random content, plus noise
  task automatic test_random_flight();
    int sent;
    sent = 0;
    while (sent < 310) begin
      if ($urandom_range(0, 99) < 75) begin
        gaps_on = ($urandom_range(0, 5) != 0);
        load_unit_attitude();
        for (int i = 0; i < 3; i++) write_elem(4'(i), small_val(23));
        sent += 7;
        for (int i = 3; i < 12; i++) begin
          if ($urandom_range(0, 2) == 0) begin
            write_elem(4'(i), small_val(30));
            sent++;
          end
        end
        repeat ($urandom_range(1, 3)) begin
          run_predict(($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(1, 50)));
          sent++;
        end
      end else begin
        repeat ($urandom_range(1, 4)) begin
          if ($urandom_range(0, 2) == 0) run_predict(16'($urandom));
          else write_elem(4'($urandom), elem_t'({$urandom, $urandom}));
          sent++;
        end
      end
      if ($urandom_range(0, 19) == 0) begin
        write_band(isps_pkg::REG_NORM_LOW, $urandom_range(0, 32'd16777216));
        write_band(isps_pkg::REG_NORM_HIGH, $urandom_range(32'd16777216, 32'd67108864));
      end
    end
    gaps_on = 1'b1;
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_state();
    test_extremes();
    test_band_settings();
    test_random_flight();
    drain();
    repeat (50) @(posedge clk);
    if (errors == 0) $display("tb_top OK");
    else $display("tb_top NOT OK");
    $finish;
  end

  initial begin
    #40ms;
    $display("tb_top NOT OK");
    $finish;
  end

endmodule

FILE: filelist.f
+incdir+design
design/isps_pkg.sv
design/isps_ctrl.sv
design/isps_dp.sv
design/inertial_state_predict_step.sv
sim/tb_top.sv
